### hw/rtl/ogf_pkg.sv
package ogf_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int WGT_W       = 16;
  localparam int EMA_W       = 40;
  localparam int FRAC_W      = 16;
  localparam int MUL_W       = 64;
  localparam int MUL_DIGIT_W = 8;
  localparam int MUL_STEPS   = MUL_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_MULT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT = 1'd1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [WGT_W-1:0] REJECT_MULT_RST   = 16'd512;
  localparam logic [WGT_W-1:0] SMOOTH_WEIGHT_RST = 16'd6554;

  typedef enum logic [1:0] {
    SEL_D2 = 2'd0,
    SEL_NQ = 2'd1,
    SEL_S2 = 2'd2,
    SEL_KV = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     walk;
    logic     diff;
    logic     mul_start;
    logic     mul_cap;
    mul_sel_t mul_sel;
    logic     cmp;
    logic     commit;
    logic     ema;
    logic     res;
  } ogf_cmd_t;

  typedef struct packed {
    logic enough;
    logic walk_done;
    logic mul_done;
    logic outlier;
  } ogf_stat_t;

endpackage

### hw/rtl/ogf_if.sv
interface ogf_in_if import ogf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, cmd, sample, input ready);
  modport sink (input valid, cmd, sample, output ready);
endinterface

interface ogf_out_if import ogf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       rejected;
  modport source (output valid, filtered, rejected, input ready);
  modport sink (input valid, filtered, rejected, output ready);
endinterface

interface ogf_cfg_if import ogf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WGT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/outlier_gated_ema_filter.sv
// Load-cell sample filter: each new-sample item is checked against the population
// mean and deviation of a window of up to WINDOW_DEPTH accepted samples (once at least
// two are held), rejected when |x - mean| exceeds reject_multiplier/256 deviations,
// and otherwise stored and folded into a Q24.16 moving average; each item gives one
// result with the rounded average and a rejected flag. A clear item resets all filter
// state and returns zero. One item is processed at a time: a tested item walks the
// window memory, then forms four products in turn on the single shared 64x64
// multiplier, which works in 8 steps of one 8-bit digit each; a rejected item then
// skips the store and the average update. A clear, and a sample taken while fewer
// than two are held, skip the walk and the products. A stalled output adds its stall to the item in flight.
// The next item is taken while a finished result waits in the output register.
module outlier_gated_ema_filter import ogf_pkg::*; #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ogf_in_if.sink    in_ch,
  ogf_out_if.source out_ch,
  ogf_cfg_if.sink   cfg_ch
);

  ogf_cmd_t  ctl;
  ogf_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  ogf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  ogf_datapath #(
    .DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .stat         (stat),
    .in_sample    (in_ch.sample),
    .cfg_we       (cfg_ch.valid && cfg_ch.ready),
    .cfg_idx      (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_filtered (out_ch.filtered),
    .out_rejected (out_ch.rejected)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was taken");

  a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl.res))
    else $error("result appeared without a result load");

  a_mul_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mul_start |=> !stat.mul_done)
    else $error("multiplier reports done right after start");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |-> ctl.load && !ctl.walk && !ctl.commit)
    else $error("clear issued outside of an item load");
`endif

endmodule

### hw/rtl/ogf_mul.sv
module ogf_mul import ogf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic               done,
  output logic [2*MUL_W-1:0] prod
);

  logic [MUL_W-1:0]     a_r;
  logic [MUL_W-1:0]     b_r;
  logic [2*MUL_W-1:0]   res_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [MUL_W+MUL_DIGIT_W-1:0] pp;
  logic [MUL_W+MUL_DIGIT_W:0]   acc;

  // shift-add, one 8-bit digit of b per cycle, accumulator shifts right
  assign pp  = a_r * b_r[MUL_DIGIT_W-1:0];
  assign acc = (MUL_W+MUL_DIGIT_W+1)'(res_r[2*MUL_W-1:MUL_W])
             + (MUL_W+MUL_DIGIT_W+1)'(pp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      res_r <= '0;
    end else if (busy_r) begin
      b_r   <= b_r >> MUL_DIGIT_W;
      res_r <= {acc[MUL_W+MUL_DIGIT_W-1:0], res_r[MUL_W-1:MUL_DIGIT_W]};
    end
  end

  assign done = done_r;
  assign prod = res_r;

endmodule

### hw/rtl/ogf_datapath.sv
module ogf_datapath import ogf_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ogf_cmd_t                   ctl,
  output ogf_stat_t                  stat,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_idx,
  input  logic [WGT_W-1:0]           cfg_data,
  output logic signed [SAMPLE_W-1:0] out_filtered,
  output logic                       out_rejected
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_W;
  localparam int SSQ_W = SQ_W + CNT_W;
  localparam int PA_W  = SAMPLE_W + WGT_W + 1;
  localparam int PB_W  = EMA_W + WGT_W + 2;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]           wptr_r;
  logic                       full_r;
  logic signed [EMA_W-1:0]    ema_r;
  logic                       ema_ok_r;
  logic [WGT_W-1:0]           k_r;
  logic [WGT_W-1:0]           w_r;
  logic signed [SAMPLE_W-1:0] x_r;

  // window walk
  logic [CNT_W-1:0]           ridx_r;
  logic                       v1_r;
  logic                       v2_r;
  logic signed [SAMPLE_W-1:0] rdata_r;
  logic signed [SAMPLE_W-1:0] sdly_r;
  logic [SQ_W-1:0]            sq_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SSQ_W-1:0]           sumsq_r;

  logic [MUL_W-1:0]    d_r;
  logic [MUL_W-1:0]    abss_r;
  logic [MUL_W-1:0]    nq_r;
  logic [MUL_W-1:0]    s2_r;
  logic [95:0]         lhs_r;
  logic [95:0]         rhs_r;
  logic                rej_r;
  logic signed [PA_W-1:0] pa_r;
  logic signed [PB_W-1:0] pb_r;
  logic signed [SAMPLE_W-1:0] out_filt_r;
  logic                       out_rej_r;

  logic [CNT_W-1:0]         n_cnt;
  logic signed [SUM_W+1:0]  nx;
  logic signed [SUM_W+1:0]  diff;
  logic signed [MUL_W-1:0]  diff64;
  logic signed [MUL_W-1:0]  sum64;
  logic [31:0]              kk;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic                     mul_done;
  logic [2*MUL_W-1:0]       mul_prod;
  logic [WGT_W:0]           wc;
  logic signed [PB_W-1:0]   pb_rnd;
  logic signed [EMA_W+1:0]  ema_sum;
  logic signed [EMA_W:0]    ema_rnd;

  assign n_cnt  = full_r ? CNT_W'(DEPTH) : CNT_W'(wptr_r);
  assign nx     = $signed({1'b0, n_cnt}) * x_r;
  assign diff   = nx - sum_r;
  assign diff64 = MUL_W'(diff);
  assign sum64  = MUL_W'(sum_r);
  assign kk     = k_r * k_r;

  always_comb begin
    unique case (ctl.mul_sel)
      SEL_D2: begin
        mul_a = d_r;
        mul_b = d_r;
      end
      SEL_NQ: begin
        mul_a = MUL_W'(n_cnt);
        mul_b = MUL_W'(sumsq_r);
      end
      SEL_S2: begin
        mul_a = abss_r;
        mul_b = abss_r;
      end
      SEL_KV: begin
        mul_a = MUL_W'(kk);
        mul_b = nq_r - s2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ogf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign wc      = (WGT_W+1)'(1 << FRAC_W) - {1'b0, w_r};
  assign pb_rnd  = pb_r + PB_W'(1 << (FRAC_W - 1));
  assign ema_sum = (EMA_W+2)'(pa_r) + (EMA_W+2)'(pb_rnd >>> FRAC_W);
  assign ema_rnd = (EMA_W+1)'(ema_r) + (EMA_W+1)'(1 << (FRAC_W - 1));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      full_r   <= 1'b0;
      ema_ok_r <= 1'b0;
      ema_r    <= '0;
      k_r      <= REJECT_MULT_RST;
      w_r      <= SMOOTH_WEIGHT_RST;
      ridx_r   <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_REJECT_MULT:   k_r <= cfg_data;
          CFG_SMOOTH_WEIGHT: w_r <= cfg_data;
          default:           k_r <= k_r;
        endcase
      end
      if (ctl.load) begin
        ridx_r <= '0;
        v1_r   <= 1'b0;
        v2_r   <= 1'b0;
      end else if (ctl.walk) begin
        v1_r <= (ridx_r < n_cnt);
        v2_r <= v1_r;
        if (ridx_r < n_cnt) begin
          ridx_r <= ridx_r + 1'b1;
        end
      end
      if (ctl.clear) begin
        wptr_r   <= '0;
        full_r   <= 1'b0;
        ema_ok_r <= 1'b0;
        ema_r    <= '0;
      end
      if (ctl.commit) begin
        if (wptr_r == IDX_W'(DEPTH - 1)) begin
          wptr_r <= '0;
          full_r <= 1'b1;
        end else begin
          wptr_r <= wptr_r + 1'b1;
        end
      end
      if (ctl.ema) begin
        ema_ok_r <= 1'b1;
        if (ema_ok_r) begin
          ema_r <= ema_sum[EMA_W-1:0];
        end else begin
          ema_r <= {x_r, {FRAC_W{1'b0}}};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      mem[wptr_r] <= x_r;
    end
    rdata_r <= mem[ridx_r[IDX_W-1:0]];
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r     <= in_sample;
      rej_r   <= 1'b0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (ctl.walk) begin
      sq_r   <= SQ_W'(rdata_r * rdata_r);
      sdly_r <= rdata_r;
      if (v2_r) begin
        sum_r   <= sum_r + SUM_W'(sdly_r);
        sumsq_r <= sumsq_r + SSQ_W'(sq_r);
      end
    end
    if (ctl.diff) begin
      d_r    <= diff64[MUL_W-1] ? -diff64 : diff64;
      abss_r <= sum64[MUL_W-1] ? -sum64 : sum64;
    end
    if (ctl.mul_cap) begin
      case (ctl.mul_sel)
        SEL_D2:  lhs_r <= {mul_prod[95-FRAC_W:0], {FRAC_W{1'b0}}};
        SEL_NQ:  nq_r  <= mul_prod[MUL_W-1:0];
        SEL_S2:  s2_r  <= mul_prod[MUL_W-1:0];
        default: rhs_r <= mul_prod[95:0];
      endcase
    end
    if (ctl.cmp) begin
      rej_r <= stat.outlier;
    end
    if (ctl.commit) begin
      pa_r <= $signed({1'b0, w_r}) * x_r;
      pb_r <= $signed({1'b0, wc}) * ema_r;
    end
    if (ctl.res) begin
      out_filt_r <= ema_rnd[EMA_W-1:FRAC_W];
      out_rej_r  <= rej_r;
    end
  end

  assign stat.enough    = (n_cnt >= CNT_W'(2));
  assign stat.walk_done = (ridx_r == n_cnt) && !v1_r && !v2_r;
  assign stat.mul_done  = mul_done;
  assign stat.outlier   = (lhs_r > rhs_r);

  assign out_filtered = out_filt_r;
  assign out_rejected = out_rej_r;

endmodule

### hw/rtl/ogf_ctrl.sv
module ogf_ctrl import ogf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  input  logic      out_ready,
  input  ogf_stat_t stat,
  output ogf_cmd_t  ctl,
  output logic      in_ready,
  output logic      out_valid
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_WALK  = 9'b000000010,
    ST_DIFF  = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_MWAIT = 9'b000010000,
    ST_CMP   = 9'b000100000,
    ST_UPD   = 9'b001000000,
    ST_EMA   = 9'b010000000,
    ST_RES   = 9'b100000000
  } state_t;

  state_t   state_r, state_nxt;
  mul_sel_t sel_r, sel_nxt;
  logic     ov_r, ov_nxt;

  always_comb begin
    ctl         = '0;
    ctl.mul_sel = sel_r;
    in_ready    = 1'b0;
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    ov_nxt      = ov_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          if (in_cmd == CMD_CLEAR) begin
            ctl.clear = 1'b1;
            state_nxt = ST_RES;
          end else if (stat.enough) begin
            state_nxt = ST_WALK;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_WALK: begin
        ctl.walk = 1'b1;
        if (stat.walk_done) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctl.diff  = 1'b1;
        sel_nxt   = SEL_D2;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul_start = 1'b1;
        state_nxt     = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat.mul_done) begin
          ctl.mul_cap = 1'b1;
          state_nxt   = ST_MUL;
          unique case (sel_r)
            SEL_D2:  sel_nxt = SEL_NQ;
            SEL_NQ:  sel_nxt = SEL_S2;
            SEL_S2:  sel_nxt = SEL_KV;
            default: state_nxt = ST_CMP;
          endcase
        end
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = stat.outlier ? ST_RES : ST_UPD;
      end
      ST_UPD: begin
        ctl.commit = 1'b1;
        state_nxt  = ST_EMA;
      end
      ST_EMA: begin
        ctl.ema   = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        // wait for the output register to free up
        if (!ov_r || out_ready) begin
          ctl.res   = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= SEL_D2;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule
